// File: rtl/core/gbfs_pkg.sv
// Shared types, constants and step tables of the grid breadth-first path finder.
package gbfs_pkg;

    localparam int CELL_W     = 6;
    localparam int DIST_W     = 7;
    localparam int CNT_W      = 7;
    localparam int IDX_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;

    localparam logic [DIST_W-1:0] NO_VALUE = 7'd127;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_WIDTH     = 3'd0,
        REG_GRID_HEIGHT    = 3'd1,
        REG_ALLOW_DIAGONAL = 3'd2,
        REG_START_CELL     = 3'd3,
        REG_FINISH_CELL    = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        CMD_WALL = 1'b0,
        CMD_RUN  = 1'b1
    } cmd_t;

    typedef struct packed {
        logic [3:0]        grid_width;
        logic [3:0]        grid_height;
        logic              allow_diagonal;
        logic [CELL_W-1:0] start_cell;
        logic [CELL_W-1:0] finish_cell;
    } cfg_t;

    typedef struct packed {
        logic              push;
        logic [CELL_W-1:0] cell_id;
        logic              emit;
        logic [CNT_W-1:0]  count;
    } path_cmd_t;

    typedef struct packed {
        logic              queued;
        logic [DIST_W-1:0] distance;
        logic [DIST_W-1:0] parent;
    } node_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_CLEAR, S_INIT, S_QRD, S_CRD, S_CLD, S_NADR,
        S_NEVAL, S_CWB, S_PWAIT, S_PFIN, S_PPUSH, S_PNEXT, S_WCLR
    } search_state_t;

    typedef enum logic [1:0] {
        P_IDLE, P_READ, P_LOAD, P_NONE
    } path_state_t;

    // Neighbor order: right, left, up, down, down-right, down-left, up-right, up-left.
    function automatic logic signed [1:0] step_dx(input logic [2:0] d);
        logic signed [1:0] r;
        case (d)
            3'd0, 3'd4, 3'd6: r = 2'sd1;
            3'd1, 3'd5, 3'd7: r = -2'sd1;
            default:          r = 2'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [1:0] step_dy(input logic [2:0] d);
        logic signed [1:0] r;
        case (d)
            3'd2, 3'd6, 3'd7: r = -2'sd1;
            3'd3, 3'd4, 3'd5: r = 2'sd1;
            default:          r = 2'sd0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/core/gbfs_if.sv
// Valid/ready channel interfaces for commands in and path results out.
interface gbfs_in_if;
    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic [gbfs_pkg::CELL_W-1:0] cell_index;
    logic                        wall_bit;

    modport source (output valid, cmd, cell_index, wall_bit, input ready);
    modport sink (input valid, cmd, cell_index, wall_bit, output ready);
endinterface

interface gbfs_out_if;
    logic                        valid;
    logic                        ready;
    logic [gbfs_pkg::CELL_W-1:0] path_cell;
    logic                        found;
    logic                        last;

    modport source (output valid, path_cell, found, last, input ready);
    modport sink (input valid, path_cell, found, last, output ready);
endinterface

// File: rtl/core/gbfs_search.sv
// Search sequencer with the wall map, node store and visit queue memories.
module gbfs_search #(
    parameter int MAX_SIDE  = 8,
    parameter int MAX_CELLS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  gbfs_pkg::cfg_t      cfg,
    gbfs_in_if.sink             req,
    input  logic                path_busy,
    output gbfs_pkg::path_cmd_t path_cmd
);

    localparam int AW     = $clog2(MAX_CELLS);
    localparam int CW     = $clog2(MAX_SIDE);
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int IDX_W  = gbfs_pkg::IDX_W;
    localparam int CNT_W  = gbfs_pkg::CNT_W;
    localparam int DIST_W = gbfs_pkg::DIST_W;
    localparam int CELL_W = gbfs_pkg::CELL_W;

    gbfs_pkg::search_state_t state_reg, state_next;

    logic [CELL_W-1:0] r_reg, r_next;
    logic [CW-1:0]     cx_reg, cx_next, cy_reg, cy_next;
    logic [CW-1:0]     nx_reg, nx_next, ny_reg, ny_next;
    logic [AW-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]  i_reg, i_next, qn_reg, qn_next, n_reg, n_next;
    logic [IDX_W-1:0]  c_reg, c_next, idx_reg, idx_next;
    logic [3:0]        dir_reg, dir_next;
    logic [DIST_W-1:0] dc_reg, dc_next, pc_reg, pc_next, p_reg, p_next;
    logic              bad_reg, bad_next;

    gbfs_pkg::node_t node_mem [MAX_CELLS];
    gbfs_pkg::node_t node_rd_reg, node_wdata;
    logic [AW-1:0]   node_waddr, node_raddr;
    logic            node_we, node_re;

    logic            wall_mem [MAX_CELLS];
    logic            wall_rd_reg;
    logic            wall_re;

    logic [2*CW-1:0] queue_mem [MAX_CELLS];
    logic [2*CW-1:0] queue_rd_reg, queue_wdata;
    logic [AW-1:0]   queue_waddr, queue_raddr;
    logic            queue_we, queue_re;

    logic [SIDE_W-1:0] w, h;
    logic [IDX_W-1:0]  total_full;
    logic [CNT_W-1:0]  total;
    logic              accept, bad;
    logic [3:0]        dir_end;
    logic signed [CW+1:0] nx_s, ny_s;
    logic [IDX_W-1:0]  n_idx, c_idx;
    logic              in_grid, give, enq;
    logic [DIST_W-1:0] cand;
    logic [CW-1:0]     qx, qy;

    always_comb
    begin
        if (cfg.grid_width == 4'd0)
            w = SIDE_W'(1);
        else if (32'(cfg.grid_width) > MAX_SIDE)
            w = SIDE_W'(MAX_SIDE);
        else
            w = SIDE_W'(cfg.grid_width);
        if (cfg.grid_height == 4'd0)
            h = SIDE_W'(1);
        else if (32'(cfg.grid_height) > MAX_SIDE)
            h = SIDE_W'(MAX_SIDE);
        else
            h = SIDE_W'(cfg.grid_height);
    end

    assign total_full = IDX_W'(w) * IDX_W'(h);
    assign total      = (total_full > IDX_W'(MAX_CELLS)) ? CNT_W'(MAX_CELLS)
                                                         : CNT_W'(total_full);
    assign bad = (CNT_W'(cfg.start_cell) >= total) || (CNT_W'(cfg.finish_cell) >= total);

    assign req.ready = (state_reg == gbfs_pkg::S_IDLE);
    assign accept    = req.valid && req.ready;

    assign dir_end = cfg.allow_diagonal ? 4'd8 : 4'd4;
    assign nx_s = $signed({2'b00, cx_reg}) + (CW+2)'(gbfs_pkg::step_dx(dir_reg[2:0]));
    assign ny_s = $signed({2'b00, cy_reg}) + (CW+2)'(gbfs_pkg::step_dy(dir_reg[2:0]));
    assign n_idx = IDX_W'(ny_s[CW-1:0]) * IDX_W'(w) + IDX_W'(nx_s[CW-1:0]);
    assign in_grid = !nx_s[CW+1] && !ny_s[CW+1]
                  && (nx_s < $signed((CW+2)'(w))) && (ny_s < $signed((CW+2)'(h)))
                  && (n_idx < IDX_W'(total));

    assign qx    = queue_rd_reg[CW-1:0];
    assign qy    = queue_rd_reg[2*CW-1:CW];
    assign c_idx = IDX_W'(qy) * IDX_W'(w) + IDX_W'(qx);

    assign cand = node_rd_reg.distance + DIST_W'(1);
    assign give = (node_rd_reg.distance != gbfs_pkg::NO_VALUE) && !wall_rd_reg
               && ((dc_reg == gbfs_pkg::NO_VALUE) || (dc_reg > cand));
    assign enq  = (idx_reg != IDX_W'(cfg.start_cell)) && !wall_rd_reg
               && !node_rd_reg.queued && (qn_reg < total);

    always_comb
    begin
        state_next  = state_reg;
        r_next      = r_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        nx_next     = nx_reg;
        ny_next     = ny_reg;
        cnt_next    = cnt_reg;
        i_next      = i_reg;
        qn_next     = qn_reg;
        n_next      = n_reg;
        c_next      = c_reg;
        idx_next    = idx_reg;
        dir_next    = dir_reg;
        dc_next     = dc_reg;
        pc_next     = pc_reg;
        p_next      = p_reg;
        bad_next    = bad_reg;
        node_we     = 1'b0;
        node_waddr  = '0;
        node_wdata  = '0;
        node_re     = 1'b0;
        node_raddr  = '0;
        wall_re     = 1'b0;
        queue_we    = 1'b0;
        queue_waddr = '0;
        queue_wdata = '0;
        queue_re    = 1'b0;
        queue_raddr = '0;
        path_cmd    = '0;
        unique case (state_reg)
            gbfs_pkg::S_WCLR:
            begin
                // Wall map clearing pass after reset, one entry a cycle.
                cnt_next = cnt_reg + AW'(1);
                if (cnt_reg == AW'(MAX_CELLS - 1))
                    state_next = gbfs_pkg::S_IDLE;
            end
            gbfs_pkg::S_IDLE:
            begin
                if (accept && req.cmd == gbfs_pkg::CMD_RUN)
                begin
                    bad_next   = bad;
                    r_next     = cfg.start_cell;
                    cy_next    = '0;
                    state_next = bad ? gbfs_pkg::S_PWAIT : gbfs_pkg::S_DIV;
                end
            end
            gbfs_pkg::S_DIV:
            begin
                // Row and column of the start cell by repeated subtraction.
                if (r_reg >= CELL_W'(w))
                begin
                    r_next  = r_reg - CELL_W'(w);
                    cy_next = cy_reg + CW'(1);
                end
                else
                begin
                    cx_next    = r_reg[CW-1:0];
                    cnt_next   = '0;
                    state_next = gbfs_pkg::S_CLEAR;
                end
            end
            gbfs_pkg::S_CLEAR:
            begin
                node_we    = 1'b1;
                node_waddr = cnt_reg;
                node_wdata = '{queued: 1'b0, distance: gbfs_pkg::NO_VALUE,
                               parent: gbfs_pkg::NO_VALUE};
                cnt_next   = cnt_reg + AW'(1);
                if (cnt_reg == AW'(MAX_CELLS - 1))
                    state_next = gbfs_pkg::S_INIT;
            end
            gbfs_pkg::S_INIT:
            begin
                node_we     = 1'b1;
                node_waddr  = cfg.start_cell[AW-1:0];
                node_wdata  = '{queued: 1'b1, distance: '0, parent: gbfs_pkg::NO_VALUE};
                queue_we    = 1'b1;
                queue_waddr = '0;
                queue_wdata = {cy_reg, cx_reg};
                qn_next     = CNT_W'(1);
                i_next      = '0;
                state_next  = gbfs_pkg::S_QRD;
            end
            gbfs_pkg::S_QRD:
            begin
                queue_re    = 1'b1;
                queue_raddr = i_reg[AW-1:0];
                state_next  = gbfs_pkg::S_CRD;
            end
            gbfs_pkg::S_CRD:
            begin
                c_next     = c_idx;
                cx_next    = qx;
                cy_next    = qy;
                node_re    = 1'b1;
                node_raddr = c_idx[AW-1:0];
                dir_next   = '0;
                state_next = gbfs_pkg::S_CLD;
            end
            gbfs_pkg::S_CLD:
            begin
                dc_next    = node_rd_reg.distance;
                pc_next    = node_rd_reg.parent;
                state_next = gbfs_pkg::S_NADR;
            end
            gbfs_pkg::S_NADR:
            begin
                if (dir_reg == dir_end)
                    state_next = gbfs_pkg::S_CWB;
                else if (in_grid)
                begin
                    node_re    = 1'b1;
                    node_raddr = n_idx[AW-1:0];
                    wall_re    = 1'b1;
                    idx_next   = n_idx;
                    nx_next    = nx_s[CW-1:0];
                    ny_next    = ny_s[CW-1:0];
                    state_next = gbfs_pkg::S_NEVAL;
                end
                else
                    dir_next = dir_reg + 4'd1;
            end
            gbfs_pkg::S_NEVAL:
            begin
                if (give)
                begin
                    dc_next = cand;
                    pc_next = DIST_W'(idx_reg);
                end
                if (enq)
                begin
                    node_we     = 1'b1;
                    node_waddr  = idx_reg[AW-1:0];
                    node_wdata  = '{queued: 1'b1, distance: node_rd_reg.distance,
                                    parent: node_rd_reg.parent};
                    queue_we    = 1'b1;
                    queue_waddr = qn_reg[AW-1:0];
                    queue_wdata = {ny_reg, nx_reg};
                    qn_next     = qn_reg + CNT_W'(1);
                end
                dir_next   = dir_reg + 4'd1;
                state_next = gbfs_pkg::S_NADR;
            end
            gbfs_pkg::S_CWB:
            begin
                node_we    = 1'b1;
                node_waddr = c_reg[AW-1:0];
                node_wdata = '{queued: 1'b1, distance: dc_reg, parent: pc_reg};
                i_next     = i_reg + CNT_W'(1);
                if (c_reg == IDX_W'(cfg.finish_cell) || (i_reg + CNT_W'(1)) >= qn_reg)
                    state_next = gbfs_pkg::S_PWAIT;
                else
                    state_next = gbfs_pkg::S_QRD;
            end
            gbfs_pkg::S_PWAIT:
            begin
                if (!path_busy)
                begin
                    if (bad_reg)
                    begin
                        path_cmd.emit = 1'b1;
                        state_next    = gbfs_pkg::S_IDLE;
                    end
                    else
                    begin
                        node_re    = 1'b1;
                        node_raddr = cfg.finish_cell[AW-1:0];
                        state_next = gbfs_pkg::S_PFIN;
                    end
                end
            end
            gbfs_pkg::S_PFIN:
            begin
                p_next = node_rd_reg.parent;
                n_next = '0;
                if (node_rd_reg.parent == gbfs_pkg::NO_VALUE)
                begin
                    path_cmd.emit = 1'b1;
                    state_next    = gbfs_pkg::S_IDLE;
                end
                else
                    state_next = gbfs_pkg::S_PPUSH;
            end
            gbfs_pkg::S_PPUSH:
            begin
                if (p_reg != gbfs_pkg::NO_VALUE && p_reg < total && n_reg < total)
                begin
                    path_cmd.push    = 1'b1;
                    path_cmd.cell_id = p_reg[CELL_W-1:0];
                    n_next           = n_reg + CNT_W'(1);
                    node_re          = 1'b1;
                    node_raddr       = p_reg[AW-1:0];
                    state_next       = gbfs_pkg::S_PNEXT;
                end
                else
                begin
                    path_cmd.emit  = 1'b1;
                    path_cmd.count = n_reg;
                    state_next     = gbfs_pkg::S_IDLE;
                end
            end
            gbfs_pkg::S_PNEXT:
            begin
                p_next     = node_rd_reg.parent;
                state_next = gbfs_pkg::S_PPUSH;
            end
            default: state_next = gbfs_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gbfs_pkg::S_WCLR;
            bad_reg   <= 1'b0;
            qn_reg    <= '0;
            i_reg     <= '0;
            n_reg     <= '0;
            cnt_reg   <= '0;
            dir_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            bad_reg   <= bad_next;
            qn_reg    <= qn_next;
            i_reg     <= i_next;
            n_reg     <= n_next;
            cnt_reg   <= cnt_next;
            dir_reg   <= dir_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg   <= r_next;
        cx_reg  <= cx_next;
        cy_reg  <= cy_next;
        nx_reg  <= nx_next;
        ny_reg  <= ny_next;
        c_reg   <= c_next;
        idx_reg <= idx_next;
        dc_reg  <= dc_next;
        pc_reg  <= pc_next;
        p_reg   <= p_next;
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
            node_mem[node_waddr] <= node_wdata;
        if (node_re)
            node_rd_reg <= node_mem[node_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == gbfs_pkg::S_WCLR)
            wall_mem[cnt_reg] <= 1'b0;
        else if (accept && req.cmd == gbfs_pkg::CMD_WALL
                 && CNT_W'(req.cell_index) < CNT_W'(MAX_CELLS))
            wall_mem[req.cell_index[AW-1:0]] <= req.wall_bit;
        if (wall_re)
            wall_rd_reg <= wall_mem[n_idx[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (queue_we)
            queue_mem[queue_waddr] <= queue_wdata;
        if (queue_re)
            queue_rd_reg <= queue_mem[queue_raddr];
    end

`ifndef SYNTH
    a_enq_not_self: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gbfs_pkg::S_NEVAL && node_we) |-> (idx_reg != c_reg))
        else $error("enqueue write hits the cell under expansion");
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gbfs_pkg::S_NEVAL) |-> (qn_reg <= total))
        else $error("visit queue grew past the grid size");
    a_read_behind_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gbfs_pkg::S_QRD) |-> (i_reg < qn_reg))
        else $error("queue read beyond the written entries");
`endif

endmodule

// File: rtl/core/gbfs_path.sv
// Path stack memory and result output register, emitting the path start first.
module gbfs_path #(
    parameter int MAX_CELLS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  gbfs_pkg::path_cmd_t path_cmd,
    output logic                path_busy,
    gbfs_out_if.source          rsp
);

    localparam int AW     = $clog2(MAX_CELLS);
    localparam int CNT_W  = gbfs_pkg::CNT_W;
    localparam int CELL_W = gbfs_pkg::CELL_W;

    gbfs_pkg::path_state_t state_reg, state_next;
    logic [CNT_W-1:0]  wp_reg, wp_next, rem_reg, rem_next;
    logic              valid_reg, valid_next;
    logic [CELL_W-1:0] cell_reg, cell_next;
    logic              found_reg, found_next, last_reg, last_next;

    logic [CELL_W-1:0] stack_mem [MAX_CELLS];
    logic [CELL_W-1:0] stack_rd_reg;
    logic              stack_re;
    logic [CNT_W-1:0]  rd_ptr;
    logic              out_free;

    assign out_free  = !valid_reg || rsp.ready;
    assign path_busy = (state_reg != gbfs_pkg::P_IDLE);
    assign rd_ptr    = rem_reg - CNT_W'(1);

    assign rsp.valid     = valid_reg;
    assign rsp.path_cell = cell_reg;
    assign rsp.found     = found_reg;
    assign rsp.last      = last_reg;

    always_comb
    begin
        state_next = state_reg;
        wp_next    = wp_reg;
        rem_next   = rem_reg;
        valid_next = valid_reg && !rsp.ready;
        cell_next  = cell_reg;
        found_next = found_reg;
        last_next  = last_reg;
        stack_re   = 1'b0;
        unique case (state_reg)
            gbfs_pkg::P_IDLE:
            begin
                if (path_cmd.push)
                    wp_next = wp_reg + CNT_W'(1);
                if (path_cmd.emit)
                begin
                    wp_next    = '0;
                    rem_next   = path_cmd.count;
                    state_next = (path_cmd.count == '0) ? gbfs_pkg::P_NONE
                                                        : gbfs_pkg::P_READ;
                end
            end
            gbfs_pkg::P_READ:
            begin
                stack_re   = 1'b1;
                state_next = gbfs_pkg::P_LOAD;
            end
            gbfs_pkg::P_LOAD:
            begin
                if (out_free)
                begin
                    valid_next = 1'b1;
                    cell_next  = stack_rd_reg;
                    found_next = 1'b1;
                    last_next  = (rem_reg == CNT_W'(1));
                    rem_next   = rd_ptr;
                    state_next = (rem_reg == CNT_W'(1)) ? gbfs_pkg::P_IDLE
                                                        : gbfs_pkg::P_READ;
                end
            end
            gbfs_pkg::P_NONE:
            begin
                if (out_free)
                begin
                    valid_next = 1'b1;
                    cell_next  = '0;
                    found_next = 1'b0;
                    last_next  = 1'b1;
                    state_next = gbfs_pkg::P_IDLE;
                end
            end
            default: state_next = gbfs_pkg::P_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gbfs_pkg::P_IDLE;
            wp_reg    <= '0;
            rem_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            rem_reg   <= rem_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg  <= cell_next;
        found_reg <= found_next;
        last_reg  <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (path_cmd.push && state_reg == gbfs_pkg::P_IDLE)
            stack_mem[wp_reg[AW-1:0]] <= path_cmd.cell_id;
        if (stack_re)
            stack_rd_reg <= stack_mem[rd_ptr[AW-1:0]];
    end

`ifndef SYNTH
    a_push_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        path_cmd.push |-> (state_reg == gbfs_pkg::P_IDLE))
        else $error("path push arrived while the stack was being emitted");
    a_hold_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.path_cell)
                                       && $stable(rsp.found) && $stable(rsp.last)))
        else $error("result changed while it waited for the receiver");
    a_miss_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.found) |-> (rsp.last && rsp.path_cell == '0))
        else $error("not-found result is not a single final transaction");
`endif

endmodule

// File: rtl/core/grid_bfs_path_finder.sv
// Top level of the grid breadth-first path finder: configuration registers and submodules.
//
// This block finds a shortest path on a grid of up to MAX_SIDE x MAX_SIDE cells. After
// reset the wall map is cleared in a pass over all MAX_CELLS entries during which no
// request is accepted. Each request transaction is either a wall write, which sets the
// wall bit of one cell and gives no result, or a run command. A run computes the start
// cell's row and column, then clears the node store one entry a cycle, and walks the
// visit queue: for each dequeued cell it reads the cell's node, reads and evaluates
// each in-grid neighbor in turn, and writes the cell back to the node memory that
// holds distance, parent and queued mark. The path is then traced back through parent
// links and emitted start first. If the finish is unreachable, a wall, equal to the
// start, or the start or finish lies outside the grid, one result with found low and
// last high is given. Configuration is written through cfg_we, cfg_index and cfg_data
// and must only change while no run is in progress. A new request is accepted while
// the last result of the previous run still waits in the output register.
module grid_bfs_path_finder #(
    parameter int MAX_SIDE  = 8,
    parameter int MAX_CELLS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    gbfs_in_if.sink                             req,
    gbfs_out_if.source                          rsp,
    input  logic                                cfg_we,
    input  logic [gbfs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gbfs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    gbfs_pkg::cfg_t      cfg_reg;
    gbfs_pkg::path_cmd_t path_cmd;
    logic                path_busy;

    // Configuration registers; writes to unlisted indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_width     <= 4'd8;
            cfg_reg.grid_height    <= 4'd8;
            cfg_reg.allow_diagonal <= 1'b0;
            cfg_reg.start_cell     <= 6'd0;
            cfg_reg.finish_cell    <= 6'd63;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gbfs_pkg::REG_GRID_WIDTH:     cfg_reg.grid_width     <= cfg_data[3:0];
                gbfs_pkg::REG_GRID_HEIGHT:    cfg_reg.grid_height    <= cfg_data[3:0];
                gbfs_pkg::REG_ALLOW_DIAGONAL: cfg_reg.allow_diagonal <= cfg_data[0];
                gbfs_pkg::REG_START_CELL:     cfg_reg.start_cell     <= cfg_data;
                gbfs_pkg::REG_FINISH_CELL:    cfg_reg.finish_cell    <= cfg_data;
                default: ;
            endcase
        end
    end

    // The search sequencer owns the wall map, node store and queue; it hands the
    // traced path to the path unit once that unit has finished the previous run.
    gbfs_search #(
        .MAX_SIDE  (MAX_SIDE),
        .MAX_CELLS (MAX_CELLS)
    ) u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .req       (req),
        .path_busy (path_busy),
        .path_cmd  (path_cmd)
    );

    // The path unit reverses the traced parent chain and drives the result channel.
    gbfs_path #(
        .MAX_CELLS (MAX_CELLS)
    ) u_path (
        .clk       (clk),
        .rst_n     (rst_n),
        .path_cmd  (path_cmd),
        .path_busy (path_busy),
        .rsp       (rsp)
    );

endmodule

// File: dv/testbench.sv
// Self-checking testbench of the grid breadth-first path finder.
`timescale 1ns / 1ps

module testbench;

    localparam int CELL_W     = gbfs_pkg::CELL_W;
    localparam int CFG_IDX_W  = gbfs_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = gbfs_pkg::CFG_DATA_W;
    localparam int GRID_CELLS = 64;
    localparam int GRID_SIDE  = 8;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic [CELL_W-1:0] cell_id;
        logic              found;
        logic              last;
    } path_result_t;

    // One row of the directed table: either a register write or a request transaction.
    // A row with known_miss set is a run whose answer is the single not-found result.
    typedef struct {
        bit                    is_cfg;
        gbfs_pkg::cfg_reg_t    reg_sel;
        logic [CFG_DATA_W-1:0] data;
        gbfs_pkg::cmd_t        cmd;
        logic [CELL_W-1:0]     cell_id;
        logic                  wall;
        bit                    known_miss;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    gbfs_in_if  req ();
    gbfs_out_if rsp ();

    grid_bfs_path_finder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the registers and the wall map, kept in step with the block.
    logic [3:0]        shadow_width;
    logic [3:0]        shadow_height;
    logic              shadow_diag;
    logic [CELL_W-1:0] shadow_start;
    logic [CELL_W-1:0] shadow_finish;
    bit                wall_map [GRID_CELLS];

    path_result_t expected_path [$];
    int error_count;
    int sender_gap_pct;
    int receiver_stall_pct;
    int quiet_cycles;

    // Neighbor steps: right, left, up, down, down-right, down-left, up-right, up-left.
    int step_x [8] = '{1, -1, 0, 0, 1, -1, 1, -1};
    int step_y [8] = '{0, 0, -1, 1, 1, 1, -1, -1};

    // 50% duty clock with a 20 ns period.
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic int clamp_side(input logic [3:0] v);
        if (v < 1)
            return 1;
        if (v > GRID_SIDE)
            return GRID_SIDE;
        return int'(v);
    endfunction

    function automatic void push_result(input int cell_id, input bit found, input bit last);
        path_result_t r;
        r.cell_id = cell_id[CELL_W-1:0];
        r.found   = found;
        r.last    = last;
        expected_path.push_back(r);
    endfunction

    // Runs the breadth-first search on the shadow state and queues the path it yields.
    function automatic void predict_path();
        int w, h, total, qn, i, c, x, y, dirs, d, nx, ny, idx, cand, p, n, k;
        int start, finish;
        int dist_of [GRID_CELLS];
        int parent [GRID_CELLS];
        bit in_queue [GRID_CELLS];
        int visit [GRID_CELLS];
        int trail [GRID_CELLS];
        w = clamp_side(shadow_width);
        h = clamp_side(shadow_height);
        total = (w * h > GRID_CELLS) ? GRID_CELLS : w * h;
        start = int'(shadow_start);
        finish = int'(shadow_finish);
        for (i = 0; i < GRID_CELLS; i++)
        begin
            dist_of[i] = int'(gbfs_pkg::NO_VALUE);
            parent[i] = int'(gbfs_pkg::NO_VALUE);
            in_queue[i] = 1'b0;
        end
        if (start >= total || finish >= total)
        begin
            push_result(0, 1'b0, 1'b1);
            return;
        end
        dist_of[start] = 0;
        visit[0] = start;
        in_queue[start] = 1'b1;
        qn = 1;
        dirs = shadow_diag ? 8 : 4;
        for (i = 0; i < qn && i < total; i++)
        begin
            c = visit[i];
            x = c % w;
            y = c / w;
            for (d = 0; d < dirs; d++)
            begin
                nx = x + step_x[d];
                ny = y + step_y[d];
                if (nx < 0 || ny < 0 || nx >= w || ny >= h)
                    continue;
                idx = ny * w + nx;
                if (idx >= total)
                    continue;
                // A valued open neighbor may shorten the distance of the current cell.
                if (dist_of[idx] != int'(gbfs_pkg::NO_VALUE) && !wall_map[idx])
                begin
                    cand = dist_of[idx] + 1;
                    if (dist_of[c] == int'(gbfs_pkg::NO_VALUE) || dist_of[c] > cand)
                    begin
                        dist_of[c] = cand & 127;
                        parent[c] = idx;
                    end
                end
                if (idx != start && !wall_map[idx] && !in_queue[idx] && qn < total)
                begin
                    in_queue[idx] = 1'b1;
                    visit[qn] = idx;
                    qn++;
                end
            end
            if (c == finish)
                break;
        end
        p = parent[finish];
        if (p == int'(gbfs_pkg::NO_VALUE))
        begin
            push_result(0, 1'b0, 1'b1);
            return;
        end
        n = 0;
        while (p != int'(gbfs_pkg::NO_VALUE) && p < total && n < total)
        begin
            trail[n] = p;
            n++;
            p = parent[p];
        end
        // The trail was collected finish side first; it leaves start first.
        for (k = 0; k < n; k++)
            push_result(trail[n - 1 - k], 1'b1, k == n - 1);
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $time, what);
        error_count++;
    endtask

    task automatic wait_drained();
        while (expected_path.size() != 0)
            @(posedge clk);
        // A wall write gives no result, so leave the block time to finish it.
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register writes happen only with the block idle.
    task automatic write_reg(input gbfs_pkg::cfg_reg_t sel,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = sel;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
        case (sel)
            gbfs_pkg::REG_GRID_WIDTH:     shadow_width = value[3:0];
            gbfs_pkg::REG_GRID_HEIGHT:    shadow_height = value[3:0];
            gbfs_pkg::REG_ALLOW_DIAGONAL: shadow_diag = value[0];
            gbfs_pkg::REG_START_CELL:     shadow_start = value;
            gbfs_pkg::REG_FINISH_CELL:    shadow_finish = value;
            default:                      ;
        endcase
    endtask

    // Offers one request transaction and, once it is accepted, updates the predictor.
    task automatic send_request(input gbfs_pkg::cmd_t cmd, input logic [CELL_W-1:0] cell_id,
                                input logic wall, input bit known_miss);
        while ($urandom_range(0, 99) < sender_gap_pct)
        begin
            @(negedge clk);
            req.valid = 1'b0;
            req.cmd = gbfs_pkg::cmd_t'($urandom_range(0, 1));
            req.cell_index = CELL_W'($urandom);
            req.wall_bit = 1'($urandom);
        end
        @(negedge clk);
        req.valid = 1'b1;
        req.cmd = cmd;
        req.cell_index = cell_id;
        req.wall_bit = wall;
        forever
        begin
            @(posedge clk);
            if (req.ready)
                break;
        end
        if (cmd == gbfs_pkg::CMD_WALL)
            wall_map[cell_id] = wall;
        else if (known_miss)
            push_result(0, 1'b0, 1'b1);
        else
            predict_path();
    endtask

    task automatic end_request();
        @(negedge clk);
        req.valid = 1'b0;
    endtask

    // Picks a grid size, often at its extremes or beyond them, and end cells mostly inside.
    task automatic random_config();
        int w, h, total;
        logic [3:0] wv, hv;
        wv = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                         : 4'($urandom_range(1, 8));
        hv = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                         : 4'($urandom_range(1, 8));
        if ($urandom_range(0, 4) == 0)
        begin
            wv = 4'd8;
            hv = 4'd8;
        end
        w = clamp_side(wv);
        h = clamp_side(hv);
        total = w * h;
        write_reg(gbfs_pkg::REG_GRID_WIDTH, {2'b00, wv});
        write_reg(gbfs_pkg::REG_GRID_HEIGHT, {2'b00, hv});
        write_reg(gbfs_pkg::REG_ALLOW_DIAGONAL, CFG_DATA_W'($urandom_range(0, 1)));
        write_reg(gbfs_pkg::REG_START_CELL,
                  ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom)
                                              : CFG_DATA_W'($urandom_range(0, total - 1)));
        write_reg(gbfs_pkg::REG_FINISH_CELL,
                  ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom)
                                              : CFG_DATA_W'($urandom_range(0, total - 1)));
    endtask

    // Mostly wall writes that sculpt the maze, with a search now and then.
    task automatic random_items(input int count, input bit pause_midway);
        int i, limit_cell;
        limit_cell = clamp_side(shadow_width) * clamp_side(shadow_height) - 1;
        if (limit_cell > GRID_CELLS - 1)
            limit_cell = GRID_CELLS - 1;
        for (i = 0; i < count; i++)
        begin
            if (pause_midway && i == count / 2)
            begin
                end_request();
                while (expected_path.size() != 0)
                    @(posedge clk);
            end
            if ($urandom_range(0, 4) == 0)
                send_request(gbfs_pkg::CMD_RUN, CELL_W'($urandom), 1'($urandom), 1'b0);
            else
                send_request(gbfs_pkg::CMD_WALL,
                             ($urandom_range(0, 7) == 0) ? CELL_W'($urandom)
                                                         : CELL_W'($urandom_range(0, limit_cell)),
                             $urandom_range(0, 99) < 30, 1'b0);
        end
        end_request();
    endtask

    // Receiver: stalls at random on every falling edge.
    always @(negedge clk)
        rsp.ready = rst_n && ($urandom_range(0, 99) >= receiver_stall_pct);

    // Result checker against the oldest expectation.
    always @(posedge clk)
    begin
        path_result_t exp_r;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_path.size() == 0)
                report_mismatch($sformatf("unexpected result cell %0d found %0b last %0b",
                                          rsp.path_cell, rsp.found, rsp.last));
            else
            begin
                exp_r = expected_path.pop_front();
                if (rsp.path_cell !== exp_r.cell_id)
                    report_mismatch($sformatf("path_cell %0d, expected %0d",
                                              rsp.path_cell, exp_r.cell_id));
                if (rsp.found !== exp_r.found)
                    report_mismatch($sformatf("found %0b, expected %0b",
                                              rsp.found, exp_r.found));
                if (rsp.last !== exp_r.last)
                    report_mismatch($sformatf("last %0b, expected %0b",
                                              rsp.last, exp_r.last));
            end
        end
    end

    // Watchdog: ends the run once nothing has moved on either channel for too long.
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    stim_row_t directed [] = '{
        // Open 8x8 grid straight after reset.
        '{1'b0, gbfs_pkg::REG_GRID_WIDTH, 6'd0, gbfs_pkg::CMD_RUN, 6'd0, 1'b0, 1'b0},
        // Finish equal to start.
        '{1'b1, gbfs_pkg::REG_FINISH_CELL, 6'd0, gbfs_pkg::CMD_WALL, 6'd0, 1'b0, 1'b0},
        '{1'b0, gbfs_pkg::REG_GRID_WIDTH, 6'd0, gbfs_pkg::CMD_RUN, 6'd0, 1'b0, 1'b1},
        // Finish cell walled in.
        '{1'b1, gbfs_pkg::REG_FINISH_CELL, 6'd63, gbfs_pkg::CMD_WALL, 6'd0, 1'b0, 1'b0},
        '{1'b0, gbfs_pkg::REG_GRID_WIDTH, 6'd0, gbfs_pkg::CMD_WALL, 6'd63, 1'b1, 1'b0},
        '{1'b0, gbfs_pkg::REG_GRID_WIDTH, 6'd0, gbfs_pkg::CMD_RUN, 6'd0, 1'b0, 1'b1},
        '{1'b0, gbfs_pkg::REG_GRID_WIDTH, 6'd0, gbfs_pkg::CMD_WALL, 6'd63, 1'b0, 1'b0},
        // Walled start hands no distance to anyone.
        '{1'b0, gbfs_pkg::REG_GRID_WIDTH, 6'd0, gbfs_pkg::CMD_WALL, 6'd0, 1'b1, 1'b0},
        '{1'b0, gbfs_pkg::REG_GRID_WIDTH, 6'd0, gbfs_pkg::CMD_RUN, 6'd0, 1'b0, 1'b1},
        '{1'b0, gbfs_pkg::REG_GRID_WIDTH, 6'd0, gbfs_pkg::CMD_WALL, 6'd0, 1'b0, 1'b0},
        // Sizes out of range clamp to an 8x1 strip, leaving the finish outside.
        '{1'b1, gbfs_pkg::REG_GRID_WIDTH, 6'd15, gbfs_pkg::CMD_WALL, 6'd0, 1'b0, 1'b0},
        '{1'b1, gbfs_pkg::REG_GRID_HEIGHT, 6'd0, gbfs_pkg::CMD_WALL, 6'd0, 1'b0, 1'b0},
        '{1'b0, gbfs_pkg::REG_GRID_WIDTH, 6'd0, gbfs_pkg::CMD_RUN, 6'd0, 1'b0, 1'b1},
        '{1'b1, gbfs_pkg::REG_FINISH_CELL, 6'd7, gbfs_pkg::CMD_WALL, 6'd0, 1'b0, 1'b0},
        '{1'b0, gbfs_pkg::REG_GRID_WIDTH, 6'd0, gbfs_pkg::CMD_RUN, 6'd0, 1'b0, 1'b0},
        // Full grid with diagonals, then reversed ends around a wall.
        '{1'b1, gbfs_pkg::REG_GRID_WIDTH, 6'd8, gbfs_pkg::CMD_WALL, 6'd0, 1'b0, 1'b0},
        '{1'b1, gbfs_pkg::REG_GRID_HEIGHT, 6'd8, gbfs_pkg::CMD_WALL, 6'd0, 1'b0, 1'b0},
        '{1'b1, gbfs_pkg::REG_FINISH_CELL, 6'd63, gbfs_pkg::CMD_WALL, 6'd0, 1'b0, 1'b0},
        '{1'b1, gbfs_pkg::REG_ALLOW_DIAGONAL, 6'd1, gbfs_pkg::CMD_WALL, 6'd0, 1'b0, 1'b0},
        '{1'b0, gbfs_pkg::REG_GRID_WIDTH, 6'd0, gbfs_pkg::CMD_RUN, 6'd0, 1'b0, 1'b0},
        '{1'b1, gbfs_pkg::REG_START_CELL, 6'd63, gbfs_pkg::CMD_WALL, 6'd0, 1'b0, 1'b0},
        '{1'b1, gbfs_pkg::REG_FINISH_CELL, 6'd0, gbfs_pkg::CMD_WALL, 6'd0, 1'b0, 1'b0},
        '{1'b0, gbfs_pkg::REG_GRID_WIDTH, 6'd0, gbfs_pkg::CMD_WALL, 6'd54, 1'b1, 1'b0},
        '{1'b0, gbfs_pkg::REG_GRID_WIDTH, 6'd0, gbfs_pkg::CMD_RUN, 6'd0, 1'b0, 1'b0}
    };

    initial
    begin
        int i, phase;
        error_count = 0;
        quiet_cycles = 0;
        sender_gap_pct = 0;
        receiver_stall_pct = 0;
        shadow_width = 4'd8;
        shadow_height = 4'd8;
        shadow_diag = 1'b0;
        shadow_start = 6'd0;
        shadow_finish = 6'd63;
        for (i = 0; i < GRID_CELLS; i++)
            wall_map[i] = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req.valid = 1'b0;
        req.cmd = gbfs_pkg::CMD_WALL;
        req.cell_index = '0;
        req.wall_bit = 1'b0;
        rsp.ready = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table: register rows wait for the block to go idle first.
        for (i = 0; i < directed.size(); i++)
        begin
            if (directed[i].is_cfg)
            begin
                end_request();
                wait_drained();
                write_reg(directed[i].reg_sel, directed[i].data);
            end
            else
                send_request(directed[i].cmd, directed[i].cell_id, directed[i].wall,
                             directed[i].known_miss);
        end
        end_request();

        // Random part in three idling modes, two register settings each.
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase / 2)
                0:
                begin
                    sender_gap_pct = 13;
                    receiver_stall_pct = 53;
                end
                1:
                begin
                    sender_gap_pct = 53;
                    receiver_stall_pct = 13;
                end
                default:
                begin
                    sender_gap_pct = 0;
                    receiver_stall_pct = 0;
                end
            endcase
            wait_drained();
            random_config();
            random_items(48, phase == 1);
        end

        while (expected_path.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: files.f
rtl/core/gbfs_pkg.sv
rtl/core/gbfs_if.sv
rtl/core/gbfs_search.sv
rtl/core/gbfs_path.sv
rtl/core/grid_bfs_path_finder.sv
dv/testbench.sv
